[design/gtg_pkg.sv]
`timescale 1ns / 1ps
// Package for the go-to-goal controller: widths, payload structs, CORDIC angle table.
// No dependencies; imported by every other design file.
package gtg_pkg;

	localparam int POS_W    = 16;
	localparam int HEAD_W   = 15;
	localparam int CFG_W    = 16;
	localparam int ANG_W    = 15;
	localparam int SPD_W    = 16;
	localparam int TURN_W   = 15;
	localparam int D_W      = POS_W + 1;
	localparam int SQ_W     = 2 * D_W;
	localparam int ROOT_W   = D_W;
	localparam int XY_W     = 28;
	localparam int Z_W      = 20;
	localparam int BRG_W    = 16;
	localparam int ERR_W    = BRG_W + 1;
	localparam int PROD_W   = CFG_W + ROOT_W;
	localparam int REG_IDX_W = 3;

	localparam int CORDIC_STAGES = 16;
	localparam int SQRT_STEPS    = ROOT_W;
	localparam int CELLS = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
	localparam int SH_W  = $clog2(CELLS);

	localparam logic signed [Z_W-1:0] HALF_PI_Q16 = Z_W'(102944);

	localparam logic [CFG_W-1:0] TARGET_X_RST  = CFG_W'(256);
	localparam logic [CFG_W-1:0] TARGET_Y_RST  = CFG_W'(256);
	localparam logic [CFG_W-1:0] GAIN_RST      = CFG_W'(256);
	localparam logic [CFG_W-1:0] MAX_SPEED_RST = CFG_W'(768);
	localparam logic [CFG_W-1:0] DIST_TOL_RST  = CFG_W'(26);
	localparam logic [ANG_W-1:0] ANG_TOL_RST   = ANG_W'(410);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TARGET_X  = 3'd0,
		REG_TARGET_Y  = 3'd1,
		REG_GAIN      = 3'd2,
		REG_MAX_SPEED = 3'd3,
		REG_DIST_TOL  = 3'd4,
		REG_ANG_TOL   = 3'd5
	} gtg_reg_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] target_x;
		logic signed [CFG_W-1:0] target_y;
		logic [CFG_W-1:0]        speed_gain;
		logic [CFG_W-1:0]        max_speed;
		logic [CFG_W-1:0]        dist_tol;
		logic [ANG_W-1:0]        ang_tol;
	} gtg_cfg_t;

	// data handed from cell to cell: isqrt remainder/root and CORDIC vector
	typedef struct packed {
		logic [SQ_W-1:0]          rem;
		logic [SQ_W-1:0]          root;
		logic signed [XY_W-1:0]   x;
		logic signed [XY_W-1:0]   y;
		logic signed [Z_W-1:0]    z;
		logic signed [HEAD_W-1:0] head;
	} gtg_cell_t;

	// per-cell constants
	typedef struct packed {
		logic                  sqrt_on;
		logic                  cordic_on;
		logic [SH_W-1:0]       shift;
		logic signed [Z_W-1:0] atan;
		logic [SQ_W-1:0]       sq_bit;
	} gtg_step_t;

	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		logic signed [Z_W-1:0] a;
		case (i)
			0:  a = Z_W'(51472);
			1:  a = Z_W'(30386);
			2:  a = Z_W'(16055);
			3:  a = Z_W'(8150);
			4:  a = Z_W'(4091);
			5:  a = Z_W'(2047);
			6:  a = Z_W'(1024);
			7:  a = Z_W'(512);
			8:  a = Z_W'(256);
			9:  a = Z_W'(128);
			10: a = Z_W'(64);
			11: a = Z_W'(32);
			12: a = Z_W'(16);
			13: a = Z_W'(8);
			14: a = Z_W'(4);
			15: a = Z_W'(2);
			16: a = Z_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic gtg_step_t cell_step(input int i);
		gtg_step_t s;
		s.sqrt_on   = (i < SQRT_STEPS);
		s.cordic_on = (i < CORDIC_STAGES);
		s.shift     = SH_W'(i);
		s.atan      = atan_q16(i);
		s.sq_bit    = (i < SQRT_STEPS) ? (SQ_W'(1) << (2 * (SQRT_STEPS - 1 - i))) : '0;
		return s;
	endfunction

endpackage

[design/gtg_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pose beats in, command beats out.
// Depends on gtg_pkg for field widths.
interface gtg_pose_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [gtg_pkg::POS_W-1:0]       pos_x;
	logic signed [gtg_pkg::POS_W-1:0]       pos_y;
	logic signed [gtg_pkg::HEAD_W-1:0]      heading;

	modport source (output valid, output pos_x, output pos_y, output heading, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

interface gtg_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [gtg_pkg::SPD_W-1:0]       linear_speed;
	logic [gtg_pkg::TURN_W-1:0]      turn_rate;

	modport source (output valid, output linear_speed, output turn_rate, input ready);
	modport sink   (input valid, input linear_speed, input turn_rate, output ready);
endinterface

[design/gtg_cell.sv]
`timescale 1ns / 1ps
// One cell of the chain: one restoring isqrt step and one CORDIC vectoring step, each enabled by its step flag.
// Depends on gtg_pkg.
module gtg_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  gtg_pkg::gtg_step_t step,
	input  logic               in_valid,
	output logic               in_ready,
	input  gtg_pkg::gtg_cell_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output gtg_pkg::gtg_cell_t out_data
);
	import gtg_pkg::*;

	logic      valid_q;
	gtg_cell_t data_q;
	gtg_cell_t nxt;
	logic [SQ_W-1:0]        trial;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_comb begin
		nxt   = in_data;
		trial = in_data.root + step.sq_bit;
		xs    = in_data.x >>> step.shift;
		ys    = in_data.y >>> step.shift;
		if (step.sqrt_on) begin
			if (in_data.rem >= trial) begin
				nxt.rem  = in_data.rem - trial;
				nxt.root = (in_data.root >> 1) + step.sq_bit;
			end else begin
				nxt.root = in_data.root >> 1;
			end
		end
		if (step.cordic_on) begin
			if (!in_data.y[XY_W-1]) begin
				nxt.x = in_data.x + ys;
				nxt.y = in_data.y - xs;
				nxt.z = in_data.z + step.atan;
			end else begin
				nxt.x = in_data.x - ys;
				nxt.y = in_data.y + xs;
				nxt.z = in_data.z - step.atan;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

endmodule

[design/gtg_front.sv]
`timescale 1ns / 1ps
// Front end: offset to target, squares and half-plane pre-rotation, sum of squares.
// Depends on gtg_pkg and gtg_if; feeds the first cell.
module gtg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  gtg_pkg::gtg_cfg_t  cfg,
	gtg_pose_if.sink           pose,
	output logic               out_valid,
	input  logic               out_ready,
	output gtg_pkg::gtg_cell_t out_data
);
	import gtg_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic r_s1, r_s2, r_s3;

	logic signed [D_W-1:0]    dx_s1, dy_s1;
	logic signed [HEAD_W-1:0] head_s1, head_s2;

	logic signed [SQ_W-1:0]   sqx, sqy;
	logic signed [XY_W-1:0]   x0, y0, xr, yr;
	logic signed [Z_W-1:0]    zr;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2;
	logic signed [XY_W-1:0]   x_s2, y_s2;
	logic signed [Z_W-1:0]    z_s2;

	gtg_cell_t data_s3;

	assign r_s3       = !v_s3 || out_ready;
	assign r_s2       = !v_s2 || r_s3;
	assign r_s1       = !v_s1 || r_s2;
	assign pose.ready = r_s1;
	assign out_valid  = v_s3;
	assign out_data   = data_s3;

	always_comb begin
		sqx = dx_s1 * dx_s1;
		sqy = dy_s1 * dy_s1;
		x0  = {{(XY_W-D_W-8){dx_s1[D_W-1]}}, dx_s1, 8'b0};
		y0  = {{(XY_W-D_W-8){dy_s1[D_W-1]}}, dy_s1, 8'b0};
		xr  = x0;
		yr  = y0;
		zr  = '0;
		if (x0[XY_W-1]) begin
			if (!y0[XY_W-1]) begin
				xr = y0;
				yr = -x0;
				zr = HALF_PI_Q16;
			end else begin
				xr = -y0;
				yr = x0;
				zr = -HALF_PI_Q16;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r_s1) v_s1 <= pose.valid;
			if (r_s2) v_s2 <= v_s1;
			if (r_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pose.valid && r_s1) begin
			dx_s1   <= {cfg.target_x[CFG_W-1], cfg.target_x} - {pose.pos_x[POS_W-1], pose.pos_x};
			dy_s1   <= {cfg.target_y[CFG_W-1], cfg.target_y} - {pose.pos_y[POS_W-1], pose.pos_y};
			head_s1 <= pose.heading;
		end
		if (v_s1 && r_s2) begin
			sqx_s2  <= sqx;
			sqy_s2  <= sqy;
			x_s2    <= xr;
			y_s2    <= yr;
			z_s2    <= zr;
			head_s2 <= head_s1;
		end
		if (v_s2 && r_s3) begin
			data_s3.rem  <= sqx_s2 + sqy_s2;
			data_s3.root <= '0;
			data_s3.x    <= x_s2;
			data_s3.y    <= y_s2;
			data_s3.z    <= z_s2;
			data_s3.head <= head_s2;
		end
	end

endmodule

[design/gtg_back.sv]
`timescale 1ns / 1ps
// Back end: heading error, tolerance checks, gain product, saturation, command register.
// Depends on gtg_pkg and gtg_if; takes the last cell's beat.
module gtg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  gtg_pkg::gtg_cfg_t  cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  gtg_pkg::gtg_cell_t in_data,
	gtg_cmd_if.source          cmd
);
	import gtg_pkg::*;

	logic v_s1, r_s1, r_s2, v_s2;

	logic signed [Z_W-1:0]   zr;
	logic signed [Z_W-1:0]   zs;
	logic signed [BRG_W-1:0] bearing;
	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W-1:0] err_abs;
	logic [ROOT_W-1:0]       root_len;

	logic               far_s1;
	logic [TURN_W-1:0]  aerr_s1;
	logic [PROD_W-1:0]  prod_s1;

	logic [SPD_W-1:0]   speed_s2;
	logic [TURN_W-1:0]  turn_s2;

	assign r_s2     = !v_s2 || cmd.ready;
	assign r_s1     = !v_s1 || r_s2;
	assign in_ready = r_s1;

	assign cmd.valid        = v_s2;
	assign cmd.linear_speed = speed_s2;
	assign cmd.turn_rate    = turn_s2;

	always_comb begin
		zr       = in_data.z + Z_W'(8);
		zs       = zr >>> 4;
		bearing  = zs[BRG_W-1:0];
		err      = {bearing[BRG_W-1], bearing}
			- {{(ERR_W-HEAD_W){in_data.head[HEAD_W-1]}}, in_data.head};
		err_abs  = err[ERR_W-1] ? -err : err;
		root_len = in_data.root[ROOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (r_s1) v_s1 <= in_valid;
			if (r_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && r_s1) begin
			far_s1  <= in_data.root > SQ_W'(cfg.dist_tol);
			aerr_s1 <= err_abs[TURN_W-1:0];
			prod_s1 <= cfg.speed_gain * root_len;
		end
		if (v_s1 && r_s2) begin
			speed_s2 <= '0;
			turn_s2  <= '0;
			if (far_s1) begin
				if (aerr_s1 > cfg.ang_tol) begin
					turn_s2 <= aerr_s1;
				end else if (prod_s1[PROD_W-1:8] > (PROD_W-8)'(cfg.max_speed)) begin
					speed_s2 <= cfg.max_speed;
				end else begin
					speed_s2 <= prod_s1[SPD_W+7:8];
				end
			end
		end
	end

endmodule

[design/go_to_goal_turn_then_drive.sv]
`timescale 1ns / 1ps
// Channel  Dir  Beat payload                      Handshake
// pose     in   pos_x, pos_y, heading             valid/ready
// cmd      out  linear_speed, turn_rate           valid/ready
// cfg      in   cfg_idx, cfg_data                 cfg_we, no stall
// One pose per cycle sustained while cmd is ready; the path runs through front, CELLS cells (17 by default), back.
// Each cell does one isqrt digit and, within the first CORDIC_STAGES cells, one CORDIC micro-rotation;
// chain length is the larger of the root width and CORDIC_STAGES.
// Reset clears all valid bits and loads the register defaults.
// A stalled cmd holds its beat; bubbles in the chain still close up and pose is taken until the chain fills.
module go_to_goal_turn_then_drive (
	input  logic                             clk,
	input  logic                             arst_n,
	gtg_pose_if.sink                         pose,
	gtg_cmd_if.source                        cmd,
	input  logic                             cfg_we,
	input  logic [gtg_pkg::REG_IDX_W-1:0]    cfg_idx,
	input  logic [gtg_pkg::CFG_W-1:0]        cfg_data
);
	import gtg_pkg::*;

	gtg_cfg_t  cfg_q;
	gtg_cell_t link_data [CELLS+1];
	logic      link_valid [CELLS+1];
	logic      link_ready [CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_x   <= TARGET_X_RST;
			cfg_q.target_y   <= TARGET_Y_RST;
			cfg_q.speed_gain <= GAIN_RST;
			cfg_q.max_speed  <= MAX_SPEED_RST;
			cfg_q.dist_tol   <= DIST_TOL_RST;
			cfg_q.ang_tol    <= ANG_TOL_RST;
		end else if (cfg_we) begin
			case (gtg_reg_t'(cfg_idx))
				REG_TARGET_X:  cfg_q.target_x   <= cfg_data;
				REG_TARGET_Y:  cfg_q.target_y   <= cfg_data;
				REG_GAIN:      cfg_q.speed_gain <= cfg_data;
				REG_MAX_SPEED: cfg_q.max_speed  <= cfg_data;
				REG_DIST_TOL:  cfg_q.dist_tol   <= cfg_data;
				REG_ANG_TOL:   cfg_q.ang_tol    <= cfg_data[ANG_W-1:0];
				default: ;
			endcase
		end
	end

	gtg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pose      (pose),
		.out_valid (link_valid[0]),
		.out_ready (link_ready[0]),
		.out_data  (link_data[0])
	);

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		gtg_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (cell_step(i)),
			.in_valid  (link_valid[i]),
			.in_ready  (link_ready[i]),
			.in_data   (link_data[i]),
			.out_valid (link_valid[i+1]),
			.out_ready (link_ready[i+1]),
			.out_data  (link_data[i+1])
		);
	end

	gtg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (link_valid[CELLS]),
		.in_ready (link_ready[CELLS]),
		.in_data  (link_data[CELLS]),
		.cmd      (cmd)
	);

endmodule
